FILE: rtl/csm_pkg.sv
// csm_pkg: shared types, codes and prefix helpers for the cidr set membership block
// no dependencies; imported by cidr_set_membership
package csm_pkg;

    localparam int DEF_POS_ENTRIES = 16;
    localparam int DEF_NEG_ENTRIES = 16;
    localparam int ADDR_W          = 64;
    localparam int PLEN_W          = 8;
    localparam int MAX_PLEN_V4     = 32;
    localparam int MAX_PLEN_V6     = 128;

    // operation codes carried in the low bits of s_tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // one stored table entry: family, clamped prefix, network address
    typedef struct packed {
        logic              v6;
        logic [PLEN_W-1:0] plen;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // limit the prefix length to the family's address width
    function automatic logic [PLEN_W-1:0] clamp_prefix(input logic v6,
                                                       input logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] lim;
        lim = v6 ? PLEN_W'(MAX_PLEN_V6) : PLEN_W'(MAX_PLEN_V4);
        return (plen > lim) ? lim : plen;
    endfunction

    // network mask {high, low} for a clamped prefix of the given family
    function automatic logic [2*ADDR_W-1:0] prefix_mask(input logic v6,
                                                        input logic [PLEN_W-1:0] plen);
        logic [2*ADDR_W-1:0] m6;
        logic [31:0]         m4;
        m6 = ~({(2*ADDR_W){1'b1}} >> plen);
        m4 = ~(32'hFFFF_FFFF >> plen);
        return v6 ? m6 : {{(2*ADDR_W-32){1'b0}}, m4};
    endfunction

endpackage

FILE: rtl/csm_ram.sv
// csm_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for both prefix tables
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cidr_set_membership.sv
// cidr_set_membership: top level of the ip prefix set with positive and negative tables
// depends on csm_pkg and csm_ram
//
// Items arrive on the s_ stream and each one yields exactly one result word on the
// m_ stream. A write appends a masked entry to the positive or negative table (status 1
// when that table is full), a clear empties both tables, and a query walks the tables
// through one shared prefix comparator, one stored entry per cycle from each table's
// single read port. A write, a clear or an unused mode takes the word and then loads
// the result register; a query takes the word, reads each stored entry of the negative
// table and then of the positive table, switching tables in between, folds in the last
// read, forms the answer and loads the result register. A new item is taken while the
// previous result still waits on m_. The tables need no clearing pass after reset: only
// entries below each fill count are ever read.
module cidr_set_membership #(
    parameter int POS_ENTRIES = csm_pkg::DEF_POS_ENTRIES,
    parameter int NEG_ENTRIES = csm_pkg::DEF_NEG_ENTRIES
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // addr_high[63:0], addr_low[127:64], prefix_len[135:128]
    input  logic [3:0]   s_tuser,  // mode[1:0], to_negative[2], is_v6[3]
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // in_set[0], status[1], zero[7:2]
);

    import csm_pkg::*;

    localparam int PAW = (POS_ENTRIES > 1) ? $clog2(POS_ENTRIES) : 1;
    localparam int NAW = (NEG_ENTRIES > 1) ? $clog2(NEG_ENTRIES) : 1;
    localparam int PCW = $clog2(POS_ENTRIES + 1);
    localparam int NCW = $clog2(NEG_ENTRIES + 1);
    localparam int IW  = (PCW > NCW) ? PCW : NCW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [PCW-1:0]      pos_count_reg, pos_count_next;
    logic [NCW-1:0]      neg_count_reg, neg_count_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                phase_neg_reg, phase_neg_next;
    logic                rvalid_reg, rvalid_next;
    logic                rneg_reg, rneg_next;
    logic                negated_reg, negated_next;
    logic                matched_reg, matched_next;
    logic                q_v6_reg, q_v6_next;
    logic [2*ADDR_W-1:0] q_addr_reg, q_addr_next;
    logic                res_in_set_reg, res_in_set_next;
    logic                res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;

    // input word fields
    mode_t               in_mode;
    logic                in_to_neg;
    logic                in_v6;
    logic [PLEN_W-1:0]   in_plen;
    logic [2*ADDR_W-1:0] in_addr;
    logic [PLEN_W-1:0]   wr_plen;
    entry_t              wr_entry;
    logic                accept;

    // table ports
    logic                pos_we, neg_we;
    entry_t              pos_rdata, neg_rdata;
    entry_t              cmp_entry;
    logic                cmp_hit;
    logic                cmp_any;
    logic                pos_issue, neg_issue;

    assign in_mode   = mode_t'(s_tuser[1:0]);
    assign in_to_neg = s_tuser[2];
    assign in_v6     = s_tuser[3];
    assign in_plen   = s_tdata[135:128];
    assign in_addr   = in_v6 ? {s_tdata[63:0], s_tdata[127:64]} : {96'd0, s_tdata[95:64]};
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    // masked entry built from the incoming write
    always_comb begin
        wr_plen        = clamp_prefix(in_v6, in_plen);
        wr_entry.v6    = in_v6;
        wr_entry.plen  = wr_plen;
        {wr_entry.hi, wr_entry.lo} = in_addr & prefix_mask(in_v6, wr_plen);
    end

    assign pos_we = accept && (in_mode == MODE_WRITE) && !in_to_neg
                    && (pos_count_reg != PCW'(POS_ENTRIES));
    assign neg_we = accept && (in_mode == MODE_WRITE) && in_to_neg
                    && (neg_count_reg != NCW'(NEG_ENTRIES));

    // read data is used only during a walk and writes happen only when idle, so no forwarding
    csm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POS_ENTRIES)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_count_reg[PAW-1:0]),
        .wdata (wr_entry),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (pos_rdata)
    );

    csm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NEG_ENTRIES)
    ) u_neg_ram (
        .aclk  (aclk),
        .we    (neg_we),
        .waddr (neg_count_reg[NAW-1:0]),
        .wdata (wr_entry),
        .raddr (idx_reg[NAW-1:0]),
        .rdata (neg_rdata)
    );

    // shared prefix comparator on the word read last cycle
    always_comb begin
        cmp_entry = rneg_reg ? neg_rdata : pos_rdata;
        cmp_hit   = (cmp_entry.v6 == q_v6_reg)
                    && ((q_addr_reg & prefix_mask(q_v6_reg, cmp_entry.plen))
                        == {cmp_entry.hi, cmp_entry.lo});
        cmp_any   = (cmp_entry.hi == '0) && (cmp_entry.lo == '0);
    end

    assign neg_issue = phase_neg_reg && (idx_reg < IW'(neg_count_reg));
    assign pos_issue = !phase_neg_reg && (idx_reg < IW'(pos_count_reg));

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        pos_count_next  = pos_count_reg;
        neg_count_next  = neg_count_reg;
        idx_next        = idx_reg;
        phase_neg_next  = phase_neg_reg;
        rvalid_next     = 1'b0;
        rneg_next       = rneg_reg;
        negated_next    = negated_reg;
        matched_next    = matched_reg;
        q_v6_next       = q_v6_reg;
        q_addr_next     = q_addr_reg;
        res_in_set_next = res_in_set_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_in_set_next = 1'b0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESP;
                    case (in_mode)
                        MODE_WRITE: begin
                            if (pos_we) begin
                                pos_count_next = pos_count_reg + 1'b1;
                            end else if (neg_we) begin
                                neg_count_next = neg_count_reg + 1'b1;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            q_v6_next      = in_v6;
                            q_addr_next    = in_addr;
                            idx_next       = '0;
                            phase_neg_next = 1'b1;
                            negated_next   = 1'b0;
                            matched_next   = (pos_count_reg == '0);
                            state_next     = ST_WALK;
                        end
                        MODE_CLEAR: begin
                            pos_count_next = '0;
                            neg_count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // fold in the entry read last cycle
                if (rvalid_reg) begin
                    if (rneg_reg) begin
                        negated_next = negated_reg || cmp_hit;
                    end else begin
                        matched_next = matched_reg || cmp_hit || cmp_any;
                    end
                end
                // issue the next read: negative table first, then positive
                if (neg_issue || pos_issue) begin
                    rvalid_next = 1'b1;
                    rneg_next   = phase_neg_reg;
                    idx_next    = idx_reg + 1'b1;
                end else if (phase_neg_reg) begin
                    phase_neg_next = 1'b0;
                    idx_next       = '0;
                end else if (!rvalid_reg) begin
                    res_in_set_next = matched_reg && !negated_reg;
                    state_next      = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_status_reg, res_in_set_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counts and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_count_reg <= '0;
            neg_count_reg <= '0;
            rvalid_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_count_reg <= pos_count_next;
            neg_count_reg <= neg_count_next;
            rvalid_reg    <= rvalid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        phase_neg_reg  <= phase_neg_next;
        rneg_reg       <= rneg_next;
        negated_reg    <= negated_next;
        matched_reg    <= matched_next;
        q_v6_reg       <= q_v6_next;
        q_addr_reg     <= q_addr_next;
        res_in_set_reg <= res_in_set_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // fill counts never pass the table depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_count_reg <= PCW'(POS_ENTRIES)) && (neg_count_reg <= NCW'(NEG_ENTRIES)))
        else $error("table fill count beyond depth");

    // tables change only when a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(pos_count_reg) && $stable(neg_count_reg))
        else $error("fill count changed without an input word");

    // read data in flight only during a query walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> (state_reg == ST_WALK))
        else $error("table read outstanding outside a walk");

endmodule
